FILE: design/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // divider geometry
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_DIVZERO   = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPER,
        ST_DIV
    } state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX,
        DIV_DONE
    } div_state_t;

    // stack memory write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ram_wr_t;

    // stack memory read port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

`default_nettype wire

FILE: design/pfe_item_if.sv
`default_nettype none

interface pfe_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       finish;

    modport source (output valid, output symbol, output finish, input ready);
    modport sink   (input valid, input symbol, input finish, output ready);
endinterface

`default_nettype wire

FILE: design/pfe_result_if.sv
`default_nettype none

interface pfe_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

FILE: design/pfe_stack_ram.sv
`default_nettype none

module pfe_stack_ram (
    input  wire logic                      clk,
    input  wire pfe_pkg::ram_wr_t          wr,
    input  wire pfe_pkg::ram_rd_t          rd,
    output logic [pfe_pkg::DATA_W-1:0]     rd_data
);
    import pfe_pkg::*;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            stack_mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= stack_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/pfe_divider.sv
`default_nettype none

module pfe_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [pfe_pkg::DATA_W-1:0] dividend,
    input  wire logic [pfe_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [pfe_pkg::DATA_W-1:0]     quotient
);
    import pfe_pkg::*;

    div_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // sequencer and datapath
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        done       = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
                    quo_next   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
                    dvs_next   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
                rem_next = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    state_next = DIV_FIX;
                end
            end
            DIV_FIX:
            begin
                // apply sign of the quotient
                if (neg_reg)
                begin
                    quo_next = DATA_W'(0) - quo_reg;
                end
                state_next = DIV_DONE;
            end
            DIV_DONE:
            begin
                done       = 1'b1;
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/postfix_expression_evaluator.sv
// Space, digit push and finish are done in idle; '+', '-' and '*' read the stack, then
// execute and write back in the operate state; '/' waits in the divide state for the
// one-bit-per-cycle divider, or writes back in the operate state on a zero divisor. One
// item is in work at a time. A finish result is valid the cycle after the finish is taken
// and waits in an output register; a further finish waits until that result is taken.
// Reset clears stack depth, sticky error and output valid; the stack memory is not cleared.
`default_nettype none

module postfix_expression_evaluator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pfe_item_if.sink      item,
    pfe_result_if.source  result
);
    import pfe_pkg::*;

    state_t             state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t            err_reg, err_next;
    logic [DATA_W-1:0]  top_reg, top_next;
    op_t                op_reg, op_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;

    ram_wr_t            wr;
    ram_rd_t            rd;
    logic [DATA_W-1:0]  rd_data;
    logic               div_start;
    logic               div_done;
    logic [DATA_W-1:0]  div_quot;

    logic               item_ready;
    logic               item_acc;
    logic [DEPTH_W-1:0] depth_m2;
    logic [DATA_W-1:0]  push_val;
    logic [DATA_W-1:0]  op_res;

    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign push_val = {{(DATA_W - 8){1'b0}}, item.symbol} - {{(DATA_W - 8){1'b0}}, CH_ZERO};
    assign item_acc = item.valid && item_ready;

    pfe_stack_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    pfe_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            err_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        op_reg         <= op_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // alu for add, subtract and multiply, lhs from memory, rhs cached top
    always_comb
    begin
        case (op_reg)
            OP_ADD:  op_res = rd_data + top_reg;
            OP_SUB:  op_res = rd_data - top_reg;
            OP_MUL:  op_res = rd_data * top_reg;
            default: op_res = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        top_next        = top_reg;
        op_next         = op_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr              = '0;
        rd              = '0;
        div_start       = 1'b0;
        item_ready      = 1'b0;

        // result word taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = !(item.finish && out_valid_reg && !result.ready);
                if (item.valid && item_ready)
                begin
                    if (item.finish)
                    begin
                        // report top and status, clear the stack
                        out_valid_next = 1'b1;
                        if (depth_reg != '0)
                        begin
                            out_value_next  = top_reg;
                            out_status_next = err_reg;
                        end
                        else
                        begin
                            out_value_next  = '0;
                            out_status_next = (err_reg != STAT_OK) ? err_reg : STAT_EMPTY;
                        end
                        depth_next = '0;
                        err_next   = STAT_OK;
                    end
                    else
                    begin
                        case (item.symbol) inside
                            CH_SPACE:
                            begin
                            end
                            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                            begin
                                if (depth_reg < DEPTH_W'(2))
                                begin
                                    if (err_reg == STAT_OK)
                                    begin
                                        err_next = STAT_UNDERFLOW;
                                    end
                                end
                                else
                                begin
                                    // fetch left operand below the cached top
                                    rd.en      = 1'b1;
                                    rd.addr    = depth_m2[ADDR_W-1:0];
                                    state_next = ST_OPER;
                                    if (item.symbol == CH_PLUS)
                                    begin
                                        op_next = OP_ADD;
                                    end
                                    else if (item.symbol == CH_MINUS)
                                    begin
                                        op_next = OP_SUB;
                                    end
                                    else if (item.symbol == CH_STAR)
                                    begin
                                        op_next = OP_MUL;
                                    end
                                    else
                                    begin
                                        op_next = OP_DIV;
                                    end
                                end
                            end
                            default:
                            begin
                                // operand push
                                if (depth_reg == DEPTH_W'(STACK_DEPTH))
                                begin
                                    if (err_reg == STAT_OK)
                                    begin
                                        err_next = STAT_OVERFLOW;
                                    end
                                end
                                else
                                begin
                                    wr.en      = 1'b1;
                                    wr.addr    = depth_reg[ADDR_W-1:0];
                                    wr.data    = push_val;
                                    top_next   = push_val;
                                    depth_next = depth_reg + DEPTH_W'(1);
                                end
                            end
                        endcase
                    end
                end
            end
            ST_OPER:
            begin
                if (op_reg == OP_DIV && top_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    // write back result in place of the two operands
                    if (op_reg == OP_DIV && err_reg == STAT_OK)
                    begin
                        err_next = STAT_DIVZERO;
                    end
                    wr.en      = 1'b1;
                    wr.addr    = depth_m2[ADDR_W-1:0];
                    wr.data    = op_res;
                    top_next   = op_res;
                    depth_next = depth_reg - DEPTH_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = depth_m2[ADDR_W-1:0];
                    wr.data    = div_quot;
                    top_next   = div_quot;
                    depth_next = depth_reg - DEPTH_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item.ready    = item_ready;
    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

    // stack depth stays within the memory
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth out of range");

    // finish clears stack and sticky error
    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && item.finish) |=> (depth_reg == '0 && err_reg == STAT_OK))
        else $error("finish did not clear the stack");

    // divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide wait");

    // sticky error keeps its first code until cleared
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != STAT_OK) |=> (err_reg == $past(err_reg) || err_reg == STAT_OK))
        else $error("sticky error overwritten");

endmodule

`default_nettype wire

FILE: tb/sv/pfe_eval_checker.sv
`timescale 1ns / 100ps

module pfe_eval_checker
    import pfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pfe_item_if       item_mon,
    pfe_result_if     result_mon,
    output int        fault_count,
    output int        outstanding
);

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } outcome_t;

    // predicted machine state
    logic [31:0] stack_mem [STACK_DEPTH];
    int          depth_now;
    status_t     first_fault;

    // finish results still owed by the block, oldest first
    outcome_t    owed_results [$];
    outcome_t    oldest;
    int          faults;

    function automatic void note_fault(input status_t code);
        if (first_fault == STAT_OK)
            first_fault = code;
    endfunction

    // a push onto a full stack is dropped
    function automatic void push_value(input logic [31:0] v);
        if (depth_now >= STACK_DEPTH) begin
            note_fault(STAT_OVERFLOW);
        end
        else begin
            stack_mem[depth_now] = v;
            depth_now++;
        end
    endfunction

    // signed division that truncates toward zero, wrapping at 32 bits
    function automatic logic [31:0] quot_toward_zero(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] q;
        mag_a = a[31] ? (32'd0 - a) : a;
        mag_b = b[31] ? (32'd0 - b) : b;
        q     = mag_a / mag_b;
        return (a[31] ^ b[31]) ? (32'd0 - q) : q;
    endfunction

    // advance the predicted stack by one accepted word
    function automatic void evaluate_word(input logic [7:0] sym, input logic fin);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        outcome_t    out;
        if (fin) begin
            if (depth_now > 0) begin
                out.value  = stack_mem[depth_now - 1];
                out.status = first_fault;
            end
            else begin
                out.value  = 32'd0;
                out.status = (first_fault != STAT_OK) ? first_fault : STAT_EMPTY;
            end
            owed_results.push_back(out);
            depth_now   = 0;
            first_fault = STAT_OK;
        end
        else if (sym == CH_SPACE) begin
            return;
        end
        else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
            if (depth_now < 2) begin
                note_fault(STAT_UNDERFLOW);
                return;
            end
            rhs = stack_mem[depth_now - 1];
            lhs = stack_mem[depth_now - 2];
            depth_now -= 2;
            if (sym == CH_PLUS)
                res = lhs + rhs;
            else if (sym == CH_MINUS)
                res = lhs - rhs;
            else if (sym == CH_STAR)
                res = lhs * rhs;
            else if (rhs == 32'd0) begin
                note_fault(STAT_DIVZERO);
                res = 32'd0;
            end
            else
                res = quot_toward_zero(lhs, rhs);
            push_value(res);
        end
        else begin
            push_value({24'd0, sym} - {24'd0, CH_ZERO});
        end
    endfunction

    function automatic void report_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%s", msg);
    endfunction

    // compare result words, then predict from item words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_now   = 0;
            first_fault = STAT_OK;
            faults      = 0;
            owed_results.delete();
            fault_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report_fault($sformatf("unexpected result word: value %0d status %0d",
                                           result_mon.value, result_mon.status));
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    if (result_mon.value !== oldest.value)
                        report_fault($sformatf("value mismatch: expected %0d (%h) got %0d (%h)",
                                               $signed(oldest.value), oldest.value,
                                               result_mon.value, result_mon.value));
                    if (result_mon.status !== oldest.status)
                        report_fault($sformatf("status mismatch: expected %0d got %0d",
                                               oldest.status, result_mon.status));
                end
            end
            if (item_mon.valid && item_mon.ready)
                evaluate_word(item_mon.symbol, item_mon.finish);
            fault_count <= faults;
            outstanding <= owed_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_postfix_expression_evaluator.sv
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator;
    import pfe_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int SILENT_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic steady;
    int   words_sent;
    int   silent_cycles;
    int   fault_count;
    int   outstanding;

    pfe_item_if   item_ch ();
    pfe_result_if result_ch ();

    postfix_expression_evaluator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    pfe_eval_checker eval_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_mon    (item_ch),
        .result_mon  (result_ch),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result side stalls at random outside the steady stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= SILENT_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one item word and hold it until taken
    task automatic send_word(input logic [7:0] sym, input logic fin);
        while (!steady && $urandom_range(0, 99) < 37)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.symbol <= sym;
        item_ch.finish <= fin;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (fin || sym != CH_SPACE)
            words_sent++;
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // mostly decimal digits, sometimes any byte that is pushed
    function automatic logic [7:0] pick_operand();
        logic [7:0] b;
        if ($urandom_range(0, 4) != 0)
            return CH_ZERO + 8'($urandom_range(0, 9));
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH);
        return b;
    endfunction

    task automatic send_finish();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // well-formed expression with random operands, operators and spaces
    task automatic send_wellformed();
        int operands;
        int pushed;
        int live;
        operands = $urandom_range(1, 8);
        pushed   = 0;
        live     = 0;
        while (pushed < operands || live > 1)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(CH_SPACE, 1'b0);
            if (pushed < operands && (live < 2 || $urandom_range(0, 1) == 1))
            begin
                send_word(pick_operand(), 1'b0);
                pushed++;
                live++;
            end
            else
            begin
                send_word(pick_operator(), 1'b0);
                live--;
            end
        end
        send_finish();
    endtask

    // fill the stack or push past its top, then a few operators
    task automatic send_overfill();
        int n;
        n = $urandom_range(16, 20);
        repeat (n)
            send_word(pick_operand(), 1'b0);
        repeat ($urandom_range(0, n - 1))
            send_word(pick_operator(), 1'b0);
        send_finish();
    endtask

    // build the most negative value and divide it by minus one
    task automatic send_min_by_minus_one();
        send_word(CH_ZERO + 8'd32, 1'b0);
        repeat (5)
        begin
            send_word(CH_ZERO + 8'd32, 1'b0);
            send_word(CH_STAR, 1'b0);
        end
        send_word(CH_ZERO + 8'd2, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_word(CH_ZERO + 8'd1, 1'b0);
        send_word(CH_MINUS, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_finish();
    endtask

    // arbitrary bytes, then finish
    task automatic send_noise();
        repeat ($urandom_range(0, 10))
            send_word(8'($urandom_range(0, 255)), 1'b0);
        send_finish();
    endtask

    // stimulus and verdict
    initial
    begin
        int pick;
        rst_n            = 1'b0;
        steady           = 1'b0;
        words_sent       = 0;
        silent_cycles    = 0;
        item_ch.valid    = 1'b0;
        item_ch.symbol   = 8'd0;
        item_ch.finish   = 1'b0;
        result_ch.ready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, space, add
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_PLUS, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(8'h00, 1'b1);
        // subtract and multiply
        send_word(CH_ZERO + 8'd9, 1'b0);
        send_word(CH_ZERO + 8'd2, 1'b0);
        send_word(CH_MINUS, 1'b0);
        send_word(CH_ZERO + 8'd3, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_PLUS, 1'b1);
        // negative quotient truncates toward zero
        send_word(8'h00, 1'b0);
        send_word(CH_ZERO + 8'd7, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SPACE, 1'b1);
        // divide by zero
        send_word(CH_ZERO + 8'd5, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(8'h7F, 1'b1);
        // underflow on an empty stack
        send_word(CH_PLUS, 1'b0);
        send_word(CH_SLASH, 1'b1);
        // finish with nothing stacked
        send_word(8'hFF, 1'b1);

        // random expressions with a steady stretch in the middle
        while (words_sent < RANDOM_WORDS + 22)
        begin
            steady <= (words_sent >= 350 && words_sent < 550);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_wellformed();
            else if (pick < 72)
                send_overfill();
            else if (pick < 77)
                send_min_by_minus_one();
            else
                send_noise();
        end
        item_ch.valid <= 1'b0;
        steady        <= 1'b0;

        // drain
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/pfe_pkg.sv
design/pfe_item_if.sv
design/pfe_result_if.sv
design/pfe_stack_ram.sv
design/pfe_divider.sv
design/postfix_expression_evaluator.sv
tb/sv/pfe_eval_checker.sv
tb/sv/tb_postfix_expression_evaluator.sv
